### sv/bsh_pkg.sv
// Shared types and constants for the barrel shifter operand unit.
// No dependencies; imported by every module in sv/.
package bsh_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int KIND_W         = 3;
	localparam int OPND_W         = 32;
	localparam int AMT_W          = 8;

	localparam logic [KIND_W-1:0] KIND_LSL = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LSR = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ASR = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ROR = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RRX = 3'd4;

	// per-transaction control carried alongside the shift word
	typedef struct packed {
		logic right_form;  // result in z[W:1], carry z[0]; else z[W-1:0], carry z[W]
		logic force_zero;  // result and carry both zero
		logic use_cin;     // carry passes through unchanged
		logic changed;
		logic cin;
	} ctrl_t;

endpackage

### sv/bsh_decode.sv
// Stage 1: decodes kind/amount into a 2W-bit shift word, a right-shift count
// and control flags. Depends on bsh_pkg.
module bsh_decode #(
	parameter int DATA_WIDTH = bsh_pkg::DATA_WIDTH_DEF,
	localparam int SW = $clog2(DATA_WIDTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid_in,
	input  logic [bsh_pkg::KIND_W-1:0]  kind,
	input  logic [bsh_pkg::OPND_W-1:0]  operand_value,
	input  logic [bsh_pkg::AMT_W-1:0]   shift_amount,
	input  logic                        immediate_form,
	input  logic                        carry_in,
	output logic                        valid_s1,
	output logic [2*DATA_WIDTH-1:0]     y_s1,
	output logic [SW-1:0]               s_s1,
	output bsh_pkg::ctrl_t              ctrl_s1
);
	import bsh_pkg::*;

	localparam logic [AMT_W-1:0] W_AMT = AMT_W'(DATA_WIDTH);
	localparam int               TBL_N = 2 ** AMT_W;

	typedef logic [SW-1:0] rot_tbl_t [TBL_N];

	// amount modulo width, worked out at elaboration
	function automatic rot_tbl_t build_rot_tbl();
		rot_tbl_t t;
		for (int i = 0; i < TBL_N; i++) begin
			t[i] = SW'(i % DATA_WIDTH);
		end
		return t;
	endfunction

	localparam rot_tbl_t ROT_TBL = build_rot_tbl();

	logic [DATA_WIDTH-1:0]   v;
	logic                    sign;
	logic [DATA_WIDTH-1:0]   fill;
	logic [AMT_W-1:0]        n_lr;
	logic [SW-1:0]           r_ror;
	logic [2*DATA_WIDTH-1:0] y_d;
	logic [SW-1:0]           s_d;
	ctrl_t                   c_d;

	assign v     = DATA_WIDTH'(operand_value);
	assign sign  = v[DATA_WIDTH-1];
	assign fill  = (kind == KIND_ASR && sign) ? '1 : '0;
	assign n_lr  = (shift_amount == '0 && immediate_form) ? W_AMT : shift_amount;
	assign r_ror = ROT_TBL[shift_amount];

	always_comb begin
		// default: pass-through via full rotation, carry unchanged
		y_d          = {v, v};
		s_d          = SW'(DATA_WIDTH - 1);
		c_d.right_form = 1'b1;
		c_d.force_zero = 1'b0;
		c_d.use_cin    = 1'b1;
		c_d.changed    = 1'b0;
		c_d.cin        = carry_in;
		unique case (kind) inside
			KIND_LSL: begin
				if (shift_amount != '0) begin
					c_d.use_cin    = 1'b0;
					c_d.changed    = 1'b1;
					c_d.right_form = 1'b0;
					y_d            = {v, {DATA_WIDTH{1'b0}}};
					if (shift_amount > W_AMT) begin
						c_d.force_zero = 1'b1;
						s_d            = '0;
					end else begin
						s_d = SW'(W_AMT - shift_amount);
					end
				end
			end
			KIND_LSR, KIND_ASR: begin
				if (n_lr != '0) begin
					c_d.use_cin = 1'b0;
					c_d.changed = 1'b1;
					y_d         = {fill, v};
					if (n_lr > W_AMT) begin
						// ASR clamps to a full-width shift; LSR clears
						c_d.force_zero = (kind == KIND_LSR);
						s_d            = SW'(DATA_WIDTH - 1);
					end else begin
						s_d = SW'(n_lr - AMT_W'(1));
					end
				end
			end
			KIND_ROR: begin
				if (shift_amount != '0) begin
					c_d.use_cin = 1'b0;
					c_d.changed = 1'b1;
					s_d = (r_ror == '0) ? SW'(DATA_WIDTH - 1) : SW'(r_ror - SW'(1));
				end
			end
			KIND_RRX: begin
				c_d.use_cin = 1'b0;
				c_d.changed = 1'b1;
				y_d         = {{(DATA_WIDTH-1){1'b0}}, carry_in, v};
				s_d         = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			y_s1    <= y_d;
			s_s1    <= s_d;
			ctrl_s1 <= c_d;
		end
	end

endmodule

### sv/bsh_shift_lo.sv
// Stage 2: right shift of the 2W-bit word by the low bits of the count.
// Depends on bsh_pkg.
module bsh_shift_lo #(
	parameter int DATA_WIDTH = bsh_pkg::DATA_WIDTH_DEF,
	localparam int SW = $clog2(DATA_WIDTH),
	localparam int LO = SW / 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    valid_s1,
	input  logic [2*DATA_WIDTH-1:0] y_s1,
	input  logic [SW-1:0]           s_s1,
	input  bsh_pkg::ctrl_t          ctrl_s1,
	output logic                    valid_s2,
	output logic [2*DATA_WIDTH-1:0] z_s2,
	output logic [SW-LO-1:0]        s_hi_s2,
	output bsh_pkg::ctrl_t          ctrl_s2
);
	import bsh_pkg::*;

	logic [2*DATA_WIDTH-1:0] z_d;

	assign z_d = y_s1 >> s_s1[LO-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			z_s2    <= z_d;
			s_hi_s2 <= s_s1[SW-1:LO];
			ctrl_s2 <= ctrl_s1;
		end
	end

endmodule

### sv/bsh_shift_hi.sv
// Stage 3: right shift by the high bits of the count, result/carry select,
// output register. Depends on bsh_pkg.
module bsh_shift_hi #(
	parameter int DATA_WIDTH = bsh_pkg::DATA_WIDTH_DEF,
	localparam int SW = $clog2(DATA_WIDTH),
	localparam int LO = SW / 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       valid_s2,
	input  logic [2*DATA_WIDTH-1:0]    z_s2,
	input  logic [SW-LO-1:0]           s_hi_s2,
	input  bsh_pkg::ctrl_t             ctrl_s2,
	output logic                       valid_s3,
	output logic [bsh_pkg::OPND_W-1:0] result_s3,
	output logic                       carry_s3,
	output logic                       changed_s3
);
	import bsh_pkg::*;

	logic [SW-1:0]           hi_amt;
	logic [2*DATA_WIDTH-1:0] z;
	logic [DATA_WIDTH-1:0]   res_d;
	logic                    carry_d;

	assign hi_amt = {s_hi_s2, {LO{1'b0}}};
	assign z      = z_s2 >> hi_amt;

	always_comb begin
		if (ctrl_s2.force_zero) begin
			res_d   = '0;
			carry_d = 1'b0;
		end else if (ctrl_s2.right_form) begin
			res_d   = z[DATA_WIDTH:1];
			carry_d = z[0];
		end else begin
			res_d   = z[DATA_WIDTH-1:0];
			carry_d = z[DATA_WIDTH];
		end
		if (ctrl_s2.use_cin) begin
			carry_d = ctrl_s2.cin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			result_s3  <= OPND_W'(res_d);
			carry_s3   <= carry_d;
			changed_s3 <= ctrl_s2.changed;
		end
	end

endmodule

### sv/arm_barrel_shifter_core.sv
// ARM-style barrel shifter operand unit: top level, three pipeline stages.
// Depends on bsh_pkg, bsh_decode, bsh_shift_lo, bsh_shift_hi.
//
// Usage
//  - Slave stream s_axis_*: one shift request per transaction. tuser carries
//    kind (LSL/LSR/ASR/ROR/RRX) and the immediate-form flag; tdata carries the
//    operand, the shift amount and the incoming carry.
//  - Master stream m_axis_*: one result per request, in order. tdata carries
//    the shifted value and shifter carry-out; tuser flags a new carry.
//  - Pipeline: decode, low-order shift and high-order shift plus select are each
//    registered before m_axis_tvalid. Throughput: one transaction per cycle while
//    m_axis_tready is high, set by the three-register pipeline; there is no iteration.
//  - Stalls: each stage advances when the next one is empty or advancing, so
//    bubbles are squeezed out while m_axis_tready is low and up to three
//    transactions are held; s_axis_tready drops only when all stages are full.
//    Nothing is dropped or duplicated.
//  - Reset (arst_n low, asynchronous): all stage valids clear and
//    s_axis_tready is held low; the unit has no other reset state, and
//    s_axis_tready rises and it accepts again as soon as arst_n is released.
module arm_barrel_shifter_core #(
	parameter int DATA_WIDTH = bsh_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [31:0] operand_value, [39:32] shift_amount,
	                                   // [40] carry_in, [47:41] zero
	input  logic [3:0]  s_axis_tuser,  // [2:0] kind, [3] immediate_form
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] shifted_value, [32] carry_out, [39:33] zero
	output logic [0:0]  m_axis_tuser   // [0] carry_changed
);
	import bsh_pkg::*;

	localparam int SW = $clog2(DATA_WIDTH);
	localparam int LO = SW / 2;

	// stage enables: a stage loads when its successor can take its contents
	logic en1, en2, en3;

	logic                    valid_s1, valid_s2, valid_s3;
	logic [2*DATA_WIDTH-1:0] y_s1, z_s2;
	logic [SW-1:0]           s_s1;
	logic [SW-LO-1:0]        s_hi_s2;
	ctrl_t                   ctrl_s1, ctrl_s2;
	logic [OPND_W-1:0]       result_s3;
	logic                    carry_s3, changed_s3;

	assign en3 = !valid_s3 || m_axis_tready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	// no transaction is taken while the stages are held in reset
	assign s_axis_tready = arst_n && en1;

	bsh_decode #(.DATA_WIDTH(DATA_WIDTH)) u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en1),
		.valid_in       (s_axis_tvalid),
		.kind           (s_axis_tuser[2:0]),
		.operand_value  (s_axis_tdata[31:0]),
		.shift_amount   (s_axis_tdata[39:32]),
		.immediate_form (s_axis_tuser[3]),
		.carry_in       (s_axis_tdata[40]),
		.valid_s1       (valid_s1),
		.y_s1           (y_s1),
		.s_s1           (s_s1),
		.ctrl_s1        (ctrl_s1)
	);

	bsh_shift_lo #(.DATA_WIDTH(DATA_WIDTH)) u_shift_lo (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_s1 (valid_s1),
		.y_s1     (y_s1),
		.s_s1     (s_s1),
		.ctrl_s1  (ctrl_s1),
		.valid_s2 (valid_s2),
		.z_s2     (z_s2),
		.s_hi_s2  (s_hi_s2),
		.ctrl_s2  (ctrl_s2)
	);

	bsh_shift_hi #(.DATA_WIDTH(DATA_WIDTH)) u_shift_hi (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en3),
		.valid_s2   (valid_s2),
		.z_s2       (z_s2),
		.s_hi_s2    (s_hi_s2),
		.ctrl_s2    (ctrl_s2),
		.valid_s3   (valid_s3),
		.result_s3  (result_s3),
		.carry_s3   (carry_s3),
		.changed_s3 (changed_s3)
	);

	assign m_axis_tvalid   = valid_s3;
	assign m_axis_tdata    = {7'd0, carry_s3, result_s3};
	assign m_axis_tuser[0] = changed_s3;

	// an empty output stage must never back-pressure the input
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// with the sink ready, an accepted transaction passes every stage and reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
		|=> m_axis_tvalid)
		else $error("transaction did not reach output in three cycles");

	// an unchanged carry is never flagged as a new one
	a_cin_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctrl_s1.use_cin |-> !ctrl_s1.changed)
		else $error("pass-through carry flagged as changed");

endmodule
